>>> rtl/core/gfmiu_pkg.sv
// ---------------------------------------------------------------------------
// gfmiu_pkg
// Shared types, constants and field helpers for the GF(2^8) multiply and
// inverse unit (AES reduction polynomial x^8+x^4+x^3+x+1).
// ---------------------------------------------------------------------------
package gfmiu_pkg;

    localparam logic [8:0] AES_POLY    = 9'h11b;
    localparam logic [4:0] EUCLID_GUARD = 5'd16;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_INV = 1'b1;

    typedef enum logic [0:0] {
        S_IDLE,
        S_CALC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic finished;
    } t_dp_status;

    // carry-less product reduced modulo the field polynomial
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = '0;
        sh  = b;
        for (int i = 0; i < 8; i++) begin
            if (a[i]) begin
                acc = acc ^ sh;
            end
            sh = sh[7] ? ({sh[6:0], 1'b0} ^ AES_POLY[7:0]) : {sh[6:0], 1'b0};
        end
        return acc;
    endfunction

    // degree of a 9-bit polynomial, zero for the zero polynomial
    function automatic logic [3:0] deg9(input logic [8:0] v);
        logic [3:0] d;
        d = '0;
        for (int k = 1; k < 9; k++) begin
            if (v[k]) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

endpackage

>>> rtl/core/gfmiu_ctrl.sv
// ---------------------------------------------------------------------------
// gfmiu_ctrl
// Request sequencer: accepts a request, runs the datapath until it reports
// completion, then hands the result to the output register.
// ---------------------------------------------------------------------------
module gfmiu_ctrl
    import gfmiu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid & ~i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                if (!i_status.finished) begin
                    o_cmd.step = 1'b1;
                end else if (!r_out_valid || i_out_ready) begin
                    // output slot free this cycle
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/gfmiu_datapath.sv
// ---------------------------------------------------------------------------
// gfmiu_datapath
// Operand registers, one shift-and-subtract step of the extended Euclidean
// algorithm per cycle, the field multiplier and the result register.
// ---------------------------------------------------------------------------
module gfmiu_datapath
    import gfmiu_pkg::*;
(
    input  logic       i_clk,
    input  t_dp_cmd    i_cmd,
    input  logic       i_req_type,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    output t_dp_status o_status,
    output logic [7:0] o_field_result
);

    logic       r_op;
    logic       r_a_zero;
    logic [7:0] r_b;
    logic [8:0] r_r0;
    logic [7:0] r_r1;
    logic [7:0] r_t0;
    logic [7:0] r_t1;
    logic [4:0] r_cnt;
    logic [7:0] r_result;

    logic [3:0] deg_r0;
    logic [3:0] deg_r1;
    logic [3:0] sh;
    logic [8:0] rem;
    logic [7:0] t_next;
    logic       swap;
    logic [7:0] result;

    assign deg_r0 = deg9(r_r0);
    assign deg_r1 = deg9({1'b0, r_r1});
    assign sh     = deg_r0 - deg_r1;
    assign rem    = r_r0 ^ ({1'b0, r_r1} << sh);
    // q*t1 built one quotient term at a time
    assign t_next = r_t0 ^ gf_mul(8'(9'd1 << sh), r_t1);
    assign swap   = (deg9(rem) < deg_r1);

    assign o_status.finished = (r_op == OP_MUL) || (r_r1 == 8'd1) || (r_r1 == 8'd0)
                               || (r_cnt == EUCLID_GUARD);

    assign result = (r_op == OP_MUL) ? gf_mul(r_r1, r_b) : (r_a_zero ? 8'd0 : r_t1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_req_type;
            r_a_zero <= (i_operand_a == 8'd0);
            r_b      <= i_operand_b;
            r_r0     <= AES_POLY;
            r_r1     <= i_operand_a;
            r_t0     <= 8'd0;
            r_t1     <= 8'd1;
            r_cnt    <= '0;
        end else if (i_cmd.step) begin
            if (swap) begin
                r_r0  <= {1'b0, r_r1};
                r_r1  <= rem[7:0];
                r_t0  <= r_t1;
                r_t1  <= t_next;
                r_cnt <= r_cnt + 5'd1;
            end else begin
                r_r0 <= rem;
                r_t0 <= t_next;
            end
        end
        if (i_cmd.emit) begin
            r_result <= result;
        end
    end

    assign o_field_result = r_result;

endmodule

>>> rtl/core/gf256_multiply_inverse_unit.sv
// ---------------------------------------------------------------------------
// gf256_multiply_inverse_unit
// GF(2^8) multiply and multiplicative inverse over the AES polynomial.
// ---------------------------------------------------------------------------
// Requests arrive on i_in_valid / o_in_ready with i_req_type (multiply or
// inverse), i_operand_a and i_operand_b; results leave on o_out_valid /
// i_out_ready with o_field_result. One request is worked on at a time.
// For a multiply, the sequencer loads the request, then writes the product
// into the output register once that register is free and returns to idle
// to accept the next request. An inverse first runs the shift-and-subtract
// steps of the Euclidean long divisions, at most 14 steps, one at a time on
// the single step unit in the datapath. Inverse of zero or one gives zero or
// one without any step, as a multiply does.
// The result sits in an output register, so a new request is accepted
// while the previous result still waits to be taken; if the receiver
// stalls, the finished request holds in the datapath until the output
// register frees. Reset (synchronous, active low) empties the output
// register and returns the sequencer to idle.
// ---------------------------------------------------------------------------
module gf256_multiply_inverse_unit
    import gfmiu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_field_result
);

    t_dp_cmd    cmd;
    t_dp_status status;

    gfmiu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gfmiu_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_status       (status),
        .o_field_result (o_field_result)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks every product and inverse that gf256_multiply_inverse_unit returns
// against a field model held here. Requests come from a queue. The sender
// and the receiver idle at random under three profiles, and the receiver
// holds off once for a long time so that the unit backs up.
// ---------------------------------------------------------------------------
module testbench;
    import gfmiu_pkg::*;

    typedef struct packed {
        logic       op;
        logic [7:0] a;
        logic [7:0] b;
    } t_field_req;

    typedef struct packed {
        t_field_req req;
        logic [7:0] value;
    } t_field_answer;

    localparam int         RANDOM_PER_PROFILE = 550;
    localparam int         SETTLE_CYCLES      = 40;
    localparam int         LONG_HOLD_CYCLES   = 250;
    localparam logic [7:0] INV_EXPONENT       = 8'd254;  // a^254 = a^-1 in GF(2^8)

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_req_type = OP_MUL;
    logic [7:0] i_operand_a = '0;
    logic [7:0] i_operand_b = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_field_result;

    t_field_req    pending_q[$];
    t_field_answer answer_q[$];

    int   send_gap_pct = 0;
    int   recv_stall_pct = 0;
    logic out_hold = 1'b0;
    bit   req_taken = 1'b0;
    int   accepted_cnt = 0;
    int   mul_cnt = 0;
    int   inv_cnt = 0;
    int   checked_cnt = 0;
    int   error_cnt = 0;

    gf256_multiply_inverse_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_field_result (o_field_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shift-and-add product, reducing each time the multiplicand overflows
    function automatic logic [7:0] field_product(logic [7:0] x, logic [7:0] y);
        logic [7:0] acc;
        logic [8:0] run;
        acc = '0;
        run = {1'b0, x};
        for (int i = 0; i < 8; i++) begin
            if (y[i]) begin
                acc ^= run[7:0];
            end
            run = run << 1;
            if (run[8]) begin
                run ^= AES_POLY;
            end
        end
        return acc;
    endfunction

    // square and multiply; zero comes out as zero on its own
    function automatic logic [7:0] field_inverse(logic [7:0] x);
        logic [7:0] acc;
        acc = 8'h01;
        for (int i = 7; i >= 0; i--) begin
            acc = field_product(acc, acc);
            if (INV_EXPONENT[i]) begin
                acc = field_product(acc, x);
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] field_answer(t_field_req r);
        return (r.op == OP_INV) ? field_inverse(r.a) : field_product(r.a, r.b);
    endfunction

    // favour the corner values now and then
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_request(logic op, logic [7:0] a, logic [7:0] b);
        pending_q.push_back('{op: op, a: a, b: b});
    endtask

    task automatic queue_random(int count);
        for (int n = 0; n < count; n++) begin
            queue_request($urandom_range(1) ? OP_INV : OP_MUL, pick_byte(),
                          8'($urandom_range(255)));
        end
    endtask

    task automatic wait_until_drained();
        while (pending_q.size() != 0 || i_in_valid || answer_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || req_taken)) begin
            req_taken = 1'b0;
            if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                t_field_req nxt;
                nxt = pending_q.pop_front();
                i_in_valid  <= 1'b1;
                i_req_type  <= nxt.op;
                i_operand_a <= nxt.a;
                i_operand_b <= nxt.b;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // accepted requests become expected answers, returned results are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                t_field_req r;
                r = '{op: i_req_type, a: i_operand_a, b: i_operand_b};
                answer_q.push_back('{req: r, value: field_answer(r)});
                req_taken = 1'b1;
                accepted_cnt++;
                if (r.op == OP_INV) begin
                    inv_cnt++;
                end else begin
                    mul_cnt++;
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (answer_q.size() == 0) begin
                    error_cnt++;
                    $display("%0t: unexpected result %02h with no request pending",
                             $realtime, o_field_result);
                end else begin
                    t_field_answer exp_ans;
                    exp_ans = answer_q.pop_front();
                    checked_cnt++;
                    if (o_field_result !== exp_ans.value) begin
                        error_cnt++;
                        $display("%0t: %s a=%02h b=%02h expected %02h actual %02h",
                                 $realtime, exp_ans.req.op == OP_INV ? "inv" : "mul",
                                 exp_ans.req.a, exp_ans.req.b, exp_ans.value,
                                 o_field_result);
                    end
                end
            end
        end
    end

    // one long output stall while requests keep coming
    initial begin
        while (accepted_cnt < 40) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        out_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        out_hold = 1'b0;
    end

    initial begin
        #1000000;
        $display("timeout with %0d results still outstanding", answer_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct   = 11;
        recv_stall_pct = 69;
        // multiply corners, reduction and a known inverse pair
        queue_request(OP_MUL, 8'h00, 8'h00);
        queue_request(OP_MUL, 8'hff, 8'hff);
        queue_request(OP_MUL, 8'h01, 8'h5a);
        queue_request(OP_MUL, 8'ha5, 8'h01);
        queue_request(OP_MUL, 8'h80, 8'h02);
        queue_request(OP_MUL, 8'h53, 8'hca);
        queue_request(OP_MUL, 8'h57, 8'h83);
        queue_request(OP_MUL, 8'hff, 8'h00);
        // inverse of zero, one and further values, and operand b ignored
        queue_request(OP_INV, 8'h00, 8'h00);
        queue_request(OP_INV, 8'h00, 8'hff);
        queue_request(OP_INV, 8'h01, 8'h00);
        queue_request(OP_INV, 8'h01, 8'hff);
        queue_request(OP_INV, 8'h53, 8'h00);
        queue_request(OP_INV, 8'hca, 8'h7e);
        queue_request(OP_INV, 8'h02, 8'h00);
        queue_request(OP_INV, 8'h80, 8'h81);
        queue_request(OP_INV, 8'hff, 8'hff);
        queue_request(OP_INV, 8'h8d, 8'h00);
        queue_random(RANDOM_PER_PROFILE);
        wait_until_drained();

        send_gap_pct   = 69;
        recv_stall_pct = 11;
        queue_random(RANDOM_PER_PROFILE);
        wait_until_drained();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        queue_random(RANDOM_PER_PROFILE);
        wait_until_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d multiplies and %0d inverses, %0d results checked,",
                 mul_cnt, inv_cnt, checked_cnt);
        $display("under three idle profiles and one long output stall");
        if (error_cnt == 0 && answer_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
